// ===== rtl/anfse_pkg.sv =====
// Shared types and constants for the advertising name filter and status extractor.
`timescale 1ns / 1ps

package anfse_pkg;

  localparam int NAME_BYTES        = 8;
  localparam int MAX_PAYLOAD_BYTES = 31;

  localparam logic [1:0] PHASE_LENGTH = 2'd0;
  localparam logic [1:0] PHASE_TYPE   = 2'd1;
  localparam logic [1:0] PHASE_VALUE  = 2'd2;

  localparam logic [7:0] TYPE_SHORT_NAME    = 8'h08;
  localparam logic [7:0] TYPE_COMPLETE_NAME = 8'h09;
  localparam logic [7:0] STATUS_ON          = 8'd1;

  localparam logic [1:0] CFG_NAME_BYTES  = 2'd0;
  localparam logic [1:0] CFG_NAME_LENGTH = 2'd1;
  localparam logic [1:0] CFG_STATUS_OFS  = 2'd2;

  localparam logic [63:0] RST_NAME_BYTES  = 64'h0057_535F_3232_4742;
  localparam logic [3:0]  RST_NAME_LENGTH = 4'd7;
  localparam logic [7:0]  RST_STATUS_OFS  = 8'd7;

  typedef struct packed {
    logic [63:0] name_bytes;
    logic [3:0]  name_length;
    logic [7:0]  status_offset;
  } cfg_t;

  typedef struct packed {
    logic       switch_on;
    logic [7:0] status_value;
    logic       name_found;
  } res_t;

  function automatic logic [3:0] eff_length(input logic [3:0] len);
    logic [3:0] n;
    n = (len > 4'(NAME_BYTES)) ? 4'(NAME_BYTES) : len;
    return n;
  endfunction

  function automatic logic [7:0] name_byte(input logic [63:0] bytes, input logic [2:0] k);
    logic [7:0] b;
    b = bytes[{k, 3'b000} +: 8];
    return b;
  endfunction

endpackage

// ===== rtl/anfse_parse.sv =====
// Per-byte payload walker: field parsing, name compare and status byte latch.
`timescale 1ns / 1ps

module anfse_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [7:0]          adv_byte,
  input  logic                last_byte,
  input  anfse_pkg::cfg_t     cfg,
  output anfse_pkg::res_t     res
);

  logic [7:0] pos_r, pos_nxt;
  logic [7:0] left_r, left_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic       ok_r, ok_nxt;
  logic       found_r, found_nxt;
  logic       stop_r, stop_nxt;
  logic [7:0] status_r, status_nxt;
  logic [3:0] eff_len;
  logic [7:0] left_dec;

  assign eff_len  = anfse_pkg::eff_length(cfg.name_length);
  assign left_dec = left_r - 8'd1;

  always_comb begin
    pos_nxt    = pos_r;
    left_nxt   = left_r;
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    ok_nxt     = ok_r;
    found_nxt  = found_r;
    stop_nxt   = stop_r;
    status_nxt = status_r;
    if (pos_r < 8'(anfse_pkg::MAX_PAYLOAD_BYTES)) begin
      if (pos_r == cfg.status_offset) begin
        status_nxt = adv_byte;
      end
      if (!stop_r) begin
        case (phase_r)
          anfse_pkg::PHASE_LENGTH: begin
            if (adv_byte == 8'd0) begin
              stop_nxt = 1'b1;
            end else begin
              left_nxt  = adv_byte;
              phase_nxt = anfse_pkg::PHASE_TYPE;
            end
          end
          anfse_pkg::PHASE_TYPE: begin
            left_nxt = left_dec;
            idx_nxt  = 4'd0;
            ok_nxt   = ((adv_byte == anfse_pkg::TYPE_SHORT_NAME) ||
                        (adv_byte == anfse_pkg::TYPE_COMPLETE_NAME)) &&
                       (left_dec <= {4'd0, eff_len});
            if (left_dec == 8'd0) begin
              if (ok_nxt) begin
                found_nxt = 1'b1;
              end
              ok_nxt    = 1'b0;
              phase_nxt = anfse_pkg::PHASE_LENGTH;
            end else begin
              phase_nxt = anfse_pkg::PHASE_VALUE;
            end
          end
          default: begin
            if (ok_r) begin
              if ((idx_r >= eff_len) ||
                  (adv_byte != anfse_pkg::name_byte(cfg.name_bytes, idx_r[2:0]))) begin
                ok_nxt = 1'b0;
              end
              if (idx_r != 4'd15) begin
                idx_nxt = idx_r + 4'd1;
              end
            end
            left_nxt = left_dec;
            if (left_dec == 8'd0) begin
              if (ok_nxt) begin
                found_nxt = 1'b1;
              end
              ok_nxt    = 1'b0;
              phase_nxt = anfse_pkg::PHASE_LENGTH;
            end
          end
        endcase
      end
    end
    if (pos_r != 8'd255) begin
      pos_nxt = pos_r + 8'd1;
    end
  end

  assign res.name_found   = found_nxt;
  assign res.status_value = status_nxt;
  assign res.switch_on    = found_nxt && (status_nxt == anfse_pkg::STATUS_ON);

  always_ff @(posedge clk) begin
    if (!rst_n || (step_en && last_byte)) begin
      pos_r    <= 8'd0;
      left_r   <= 8'd0;
      phase_r  <= anfse_pkg::PHASE_LENGTH;
      idx_r    <= 4'd0;
      ok_r     <= 1'b0;
      found_r  <= 1'b0;
      stop_r   <= 1'b0;
      status_r <= 8'd0;
    end else if (step_en) begin
      pos_r    <= pos_nxt;
      left_r   <= left_nxt;
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      ok_r     <= ok_nxt;
      found_r  <= found_nxt;
      stop_r   <= stop_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

// ===== rtl/adv_name_filter_status_extract.sv =====
// Top level: input register, payload walker, configuration registers, result register.
//
// Usage: payload bytes enter on the in_ stream channel, one byte per transfer, with
// in_tlast high on the final byte. Each byte is captured in an input register and
// then walks the length/type/value parser; a byte can be taken every cycle.
// On the final byte one result transfer leaves on the out_ channel: name found,
// the status byte and the switch flag. The final byte is held in the input register,
// then its result is registered in the output register that drives out_tvalid;
// throughput is one byte per cycle while no final byte waits on a held result.
// A held result in the output register does not block input: bytes that are not
// final keep flowing, and only a final byte waits for the output register to free.
// The cfg_ channel writes the name bytes, name length and status offset by index;
// write only while no payload is in flight. cfg_ready is always high.
// Reset (rst_n low, synchronous) empties both registers, clears the payload state
// and loads the default name, length 7 and status offset 7.
`timescale 1ns / 1ps

module adv_name_filter_status_extract (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] adv_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] name_found, [8:1] status_value, [9] switch_on
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  anfse_pkg::cfg_t cfg_r;
  anfse_pkg::res_t res;

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       out_v_r;
  anfse_pkg::res_t out_res_r;
  logic       adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.name_bytes    <= anfse_pkg::RST_NAME_BYTES;
      cfg_r.name_length   <= anfse_pkg::RST_NAME_LENGTH;
      cfg_r.status_offset <= anfse_pkg::RST_STATUS_OFS;
    end else if (cfg_valid) begin
      case (cfg_index)
        anfse_pkg::CFG_NAME_BYTES:  cfg_r.name_bytes    <= cfg_data;
        anfse_pkg::CFG_NAME_LENGTH: cfg_r.name_length   <= cfg_data[3:0];
        anfse_pkg::CFG_STATUS_OFS:  cfg_r.status_offset <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // advance the held byte unless it is final and the result slot is full and not being read
  assign adv       = in_v_r && (!in_last_r || !out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  anfse_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (adv),
    .adv_byte  (in_byte_r),
    .last_byte (in_last_r),
    .cfg       (cfg_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && in_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, out_res_r};

endmodule
